FILE: rtl/core/ttmc_pkg.sv
package ttmc_pkg;

    // Field widths of one input beat and one result beat.
    localparam int OP_W     = 2;
    localparam int IDX_W    = 6;
    localparam int WEIGHT_W = 16;
    localparam int MEAN_W   = 32;
    localparam int TENSOR_W = 24;
    localparam int COORD_W  = 32;
    localparam int CINDEX_W = 16;

    // Arithmetic widths: Q4.12 weights, Q.16 products, 48-bit accumulator.
    localparam int ACC_W      = 48;
    localparam int FRAC_SHIFT = 12;
    localparam int PROD1_W    = TENSOR_W + WEIGHT_W;
    localparam int PART_W     = PROD1_W - FRAC_SHIFT;
    localparam int PROD2_W    = PART_W + WEIGHT_W;
    localparam int TERM_W     = PROD2_W - FRAC_SHIFT;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_LOAD_SKULL  = 2'd0;
    localparam t_op OP_LOAD_TISSUE = 2'd1;
    localparam t_op OP_START       = 2'd2;
    localparam t_op OP_TERM        = 2'd3;

    // Control that travels with one tensor term through the datapath.
    typedef struct packed {
        logic final_term;
        logic in_range;
    } t_term_ctl;

endpackage

FILE: rtl/core/ttmc_if.sv
interface ttmc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic        [ttmc_pkg::OP_W-1:0]       operation;
    logic        [ttmc_pkg::IDX_W-1:0]      skull_index;
    logic        [ttmc_pkg::IDX_W-1:0]      tissue_index;
    logic signed [ttmc_pkg::WEIGHT_W-1:0]   weight_value;
    logic signed [ttmc_pkg::MEAN_W-1:0]     mean_value;
    logic signed [ttmc_pkg::TENSOR_W-1:0]   tensor_value;
    logic                                   final_term;

    modport source (
        output valid, operation, skull_index, tissue_index, weight_value,
               mean_value, tensor_value, final_term,
        input  ready
    );
    modport sink (
        input  valid, operation, skull_index, tissue_index, weight_value,
               mean_value, tensor_value, final_term,
        output ready
    );
endinterface

interface ttmc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ttmc_pkg::COORD_W-1:0]    coordinate_value;
    logic        [ttmc_pkg::CINDEX_W-1:0]   coordinate_index;
    logic                                   saturated;

    modport source (
        output valid, coordinate_value, coordinate_index, saturated,
        input  ready
    );
    modport sink (
        input  valid, coordinate_value, coordinate_index, saturated,
        output ready
    );
endinterface

FILE: rtl/core/ttmc_weight_mem.sv
module ttmc_weight_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [AW-1:0]                        i_wr_addr,
    input  logic [ttmc_pkg::WEIGHT_W-1:0]        i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [AW-1:0]                        i_rd_addr,
    output logic signed [ttmc_pkg::WEIGHT_W-1:0] o_rd_data
);

    logic [ttmc_pkg::WEIGHT_W-1:0] r_mem [DEPTH];
    logic [ttmc_pkg::WEIGHT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read, so later stages may use it late.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = $signed(r_rd_data);

endmodule

FILE: rtl/core/ttmc_term_unit.sv
module ttmc_term_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  ttmc_pkg::t_term_ctl                  i_ctl,
    input  logic signed [ttmc_pkg::TENSOR_W-1:0] i_tensor_value,
    input  logic signed [ttmc_pkg::WEIGHT_W-1:0] i_skull_weight,
    input  logic signed [ttmc_pkg::WEIGHT_W-1:0] i_tissue_weight,
    input  logic                                 i_take,
    output logic                                 o_valid,
    output ttmc_pkg::t_term_ctl                  o_ctl,
    output logic signed [ttmc_pkg::TERM_W-1:0]   o_term
);

    logic                                   r_s1_valid;
    ttmc_pkg::t_term_ctl                    r_s1_ctl;
    logic signed [ttmc_pkg::TENSOR_W-1:0]   r_s1_tensor;
    logic                                   r_s2_valid;
    ttmc_pkg::t_term_ctl                    r_s2_ctl;
    logic signed [ttmc_pkg::PART_W-1:0]     r_s2_part;
    logic                                   r_s3_valid;
    ttmc_pkg::t_term_ctl                    r_s3_ctl;
    logic signed [ttmc_pkg::TERM_W-1:0]     r_s3_term;

    logic signed [ttmc_pkg::PROD1_W-1:0]    w_prod1;
    logic signed [ttmc_pkg::PROD2_W-1:0]    w_prod2;
    logic signed [ttmc_pkg::TERM_W-1:0]     n_term;

    // Dropping the low twelve bits of a signed product is a floor division.
    assign w_prod1 = r_s1_tensor * i_skull_weight;
    assign w_prod2 = r_s2_part * i_tissue_weight;

    always_comb begin
        if (r_s2_ctl.in_range) begin
            n_term = w_prod2[ttmc_pkg::PROD2_W-1:ttmc_pkg::FRAC_SHIFT];
        end else begin
            n_term = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_start;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) begin
                r_s3_valid <= 1'b1;
            end else if (i_take) begin
                r_s3_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s1_ctl    <= i_ctl;
            r_s1_tensor <= i_tensor_value;
        end
        if (r_s1_valid) begin
            r_s2_ctl  <= r_s1_ctl;
            r_s2_part <= w_prod1[ttmc_pkg::PROD1_W-1:ttmc_pkg::FRAC_SHIFT];
        end
        if (r_s2_valid) begin
            r_s3_ctl  <= r_s2_ctl;
            r_s3_term <= n_term;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_ctl   = r_s3_ctl;
    assign o_term  = r_s3_term;

endmodule

FILE: rtl/core/ttmc_accum.sv
module ttmc_accum #(
    parameter int COORDINATES = 65536
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load_mean,
    input  logic signed [ttmc_pkg::MEAN_W-1:0]   i_mean_value,
    input  logic                                 i_term_valid,
    input  ttmc_pkg::t_term_ctl                  i_term_ctl,
    input  logic signed [ttmc_pkg::TERM_W-1:0]   i_term,
    input  logic                                 i_out_ready,
    output logic                                 o_take,
    output logic                                 o_out_valid,
    output logic signed [ttmc_pkg::COORD_W-1:0]  o_coordinate_value,
    output logic [ttmc_pkg::CINDEX_W-1:0]        o_coordinate_index,
    output logic                                 o_saturated
);

    localparam int ACC_W  = ttmc_pkg::ACC_W;
    localparam int TERM_W = ttmc_pkg::TERM_W;
    localparam int MEAN_W = ttmc_pkg::MEAN_W;
    localparam int OUT_W  = ttmc_pkg::COORD_W;
    localparam int CNT_W  = ttmc_pkg::CINDEX_W;

    logic [ACC_W-1:0]             r_acc;
    logic [CNT_W-1:0]             r_count;
    logic                         r_out_valid;
    logic signed [OUT_W-1:0]      r_out_value;
    logic [CNT_W-1:0]             r_out_index;
    logic                         r_out_sat;

    logic [ACC_W-1:0]             w_sum;
    logic [ACC_W-OUT_W:0]         w_hi;
    logic                         w_pos_ovf;
    logic                         w_neg_ovf;
    logic signed [OUT_W-1:0]      w_clipped;
    logic                         w_out_free;
    logic                         w_emit;
    logic [CNT_W:0]               w_next;
    logic [CNT_W-1:0]             n_count;

    assign w_sum = r_acc + {{(ACC_W-TERM_W){i_term[TERM_W-1]}}, i_term};

    // The sum fits in Q16.16 when its top bits are all copies of the sign.
    assign w_hi      = w_sum[ACC_W-1:OUT_W-1];
    assign w_pos_ovf = !w_sum[ACC_W-1] && (|w_hi);
    assign w_neg_ovf = w_sum[ACC_W-1] && !(&w_hi);

    always_comb begin
        if (w_pos_ovf) begin
            w_clipped = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (w_neg_ovf) begin
            w_clipped = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            w_clipped = $signed(w_sum[OUT_W-1:0]);
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_take     = i_term_valid && (!i_term_ctl.final_term || w_out_free);
    assign w_emit     = o_take && i_term_ctl.final_term;

    assign w_next = {1'b0, r_count} + {{CNT_W{1'b0}}, 1'b1};

    always_comb begin
        if (w_next[CNT_W] || (32'(w_next) >= COORDINATES)) begin
            n_count = '0;
        end else begin
            n_count = w_next[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load_mean) begin
                r_acc <= {{(ACC_W-MEAN_W){i_mean_value[MEAN_W-1]}}, i_mean_value};
            end else if (w_emit) begin
                r_acc <= '0;
            end else if (o_take) begin
                r_acc <= w_sum;
            end
            if (w_emit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_value <= w_clipped;
            r_out_index <= r_count;
            r_out_sat   <= w_pos_ovf || w_neg_ovf;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_coordinate_value = r_out_value;
    assign o_coordinate_index = r_out_index;
    assign o_saturated        = r_out_sat;

endmodule

FILE: rtl/core/tensor_two_mode_contraction.sv
// A final tensor term reaches the output through the weight read, the two registered
// multiplies and the add; it waits further while the previous result is still held on
// the output. Weight loads and coordinate starts take one beat per cycle while no tensor
// term is in flight, and a tensor term holds off all other beats until it is accumulated.
// Reset (synchronous, active low) clears the accumulator, the coordinate counter and all
// control; the weight memories keep their contents and must be loaded before use.
module tensor_two_mode_contraction #(
    parameter int SKULL_WEIGHTS  = 64,
    parameter int TISSUE_WEIGHTS = 64,
    parameter int COORDINATES    = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ttmc_in_if.sink   i_in,
    ttmc_out_if.source o_out
);

    // Address widths of the two weight memories; a depth of one still gets one bit.
    localparam int SW_AW = (SKULL_WEIGHTS > 1) ? $clog2(SKULL_WEIGHTS) : 1;
    localparam int TW_AW = (TISSUE_WEIGHTS > 1) ? $clog2(TISSUE_WEIGHTS) : 1;

    // The sequencer has two states: taking beats, or waiting for one tensor
    // term to pass through the datapath and into the accumulator.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic                                  r_state;
    logic                                  n_state;

    logic                                  w_accept;
    logic                                  w_skull_ok;
    logic                                  w_tissue_ok;
    logic                                  w_term_start;
    ttmc_pkg::t_term_ctl                   w_in_ctl;
    logic [SW_AW-1:0]                      w_skull_addr;
    logic [TW_AW-1:0]                      w_tissue_addr;

    logic signed [ttmc_pkg::WEIGHT_W-1:0]  w_skull_weight;
    logic signed [ttmc_pkg::WEIGHT_W-1:0]  w_tissue_weight;

    logic                                  w_term_valid;
    ttmc_pkg::t_term_ctl                   w_term_ctl;
    logic signed [ttmc_pkg::TERM_W-1:0]    w_term;
    logic                                  w_take;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    // Indices beyond a weight vector are dropped on load and give a zero term.
    assign w_skull_ok  = 32'(i_in.skull_index) < SKULL_WEIGHTS;
    assign w_tissue_ok = 32'(i_in.tissue_index) < TISSUE_WEIGHTS;

    assign w_skull_addr  = SW_AW'(i_in.skull_index);
    assign w_tissue_addr = TW_AW'(i_in.tissue_index);

    assign w_term_start = w_accept && (i_in.operation == ttmc_pkg::OP_TERM);

    assign w_in_ctl.final_term = i_in.final_term;
    assign w_in_ctl.in_range   = w_skull_ok && w_tissue_ok;

    // Only one term is in flight, and no load is taken until it has been
    // accumulated, so a read never meets a write to the same entry and the
    // memories need no forwarding.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_term_start) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Skull weights, indexed by j. Written by load beats, read by term beats.
    ttmc_weight_mem #(
        .DEPTH (SKULL_WEIGHTS),
        .AW    (SW_AW)
    ) u_skull_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && (i_in.operation == ttmc_pkg::OP_LOAD_SKULL) && w_skull_ok),
        .i_wr_addr (w_skull_addr),
        .i_wr_data (i_in.weight_value),
        .i_rd_en   (w_term_start),
        .i_rd_addr (w_skull_addr),
        .o_rd_data (w_skull_weight)
    );

    // Soft-tissue weights, indexed by k.
    ttmc_weight_mem #(
        .DEPTH (TISSUE_WEIGHTS),
        .AW    (TW_AW)
    ) u_tissue_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && (i_in.operation == ttmc_pkg::OP_LOAD_TISSUE) && w_tissue_ok),
        .i_wr_addr (w_tissue_addr),
        .i_wr_data (i_in.weight_value),
        .i_rd_en   (w_term_start),
        .i_rd_addr (w_tissue_addr),
        .o_rd_data (w_tissue_weight)
    );

    // T times the skull weight, floored to Q.16, then times the tissue weight,
    // floored again; each multiply has its own register stage.
    ttmc_term_unit u_term (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_term_start),
        .i_ctl           (w_in_ctl),
        .i_tensor_value  (i_in.tensor_value),
        .i_skull_weight  (w_skull_weight),
        .i_tissue_weight (w_tissue_weight),
        .i_take          (w_take),
        .o_valid         (w_term_valid),
        .o_ctl           (w_term_ctl),
        .o_term          (w_term)
    );

    // The 48-bit accumulator wraps; a final term clips the sum to Q16.16,
    // loads the output register with the running coordinate number and
    // clears the accumulator. A start beat loads the mean directly.
    ttmc_accum #(
        .COORDINATES (COORDINATES)
    ) u_accum (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load_mean        (w_accept && (i_in.operation == ttmc_pkg::OP_START)),
        .i_mean_value       (i_in.mean_value),
        .i_term_valid       (w_term_valid),
        .i_term_ctl         (w_term_ctl),
        .i_term             (w_term),
        .i_out_ready        (o_out.ready),
        .o_take             (w_take),
        .o_out_valid        (o_out.valid),
        .o_coordinate_value (o_out.coordinate_value),
        .o_coordinate_index (o_out.coordinate_index),
        .o_saturated        (o_out.saturated)
    );

endmodule

FILE: dv/tb_tensor_two_mode_contraction.sv
`timescale 1ns / 100ps

module tb_tensor_two_mode_contraction;

    // The block is built with its default sizes; the predictor uses the same values.
    localparam int SKULL_WEIGHTS  = 64;
    localparam int TISSUE_WEIGHTS = 64;
    localparam int COORDINATES    = 65536;
    localparam int REPORT_LIMIT   = 10;

    localparam int IDX_W      = ttmc_pkg::IDX_W;
    localparam int WEIGHT_W   = ttmc_pkg::WEIGHT_W;
    localparam int MEAN_W     = ttmc_pkg::MEAN_W;
    localparam int TENSOR_W   = ttmc_pkg::TENSOR_W;
    localparam int COORD_W    = ttmc_pkg::COORD_W;
    localparam int CINDEX_W   = ttmc_pkg::CINDEX_W;
    localparam int ACC_W      = ttmc_pkg::ACC_W;
    localparam int FRAC_SHIFT = ttmc_pkg::FRAC_SHIFT;

    // One input beat, with every field at the width the interface carries.
    typedef struct {
        ttmc_pkg::t_op              operation;
        logic [IDX_W-1:0]           skull_index;
        logic [IDX_W-1:0]           tissue_index;
        logic signed [WEIGHT_W-1:0] weight_value;
        logic signed [MEAN_W-1:0]   mean_value;
        logic signed [TENSOR_W-1:0] tensor_value;
        logic                       final_term;
    } t_beat;

    // One finished coordinate as it leaves the block.
    typedef struct {
        logic signed [COORD_W-1:0] coordinate_value;
        logic [CINDEX_W-1:0]       coordinate_index;
        logic                      saturated;
    } t_coord;

    // The scoreboard keeps its own copy of both weight vectors, the accumulator and the
    // coordinate counter. Every accepted input beat is replayed here, and a final tensor
    // term turns the accumulator into an expected coordinate.
    class coordinate_scoreboard;
        logic signed [WEIGHT_W-1:0] skull_w  [SKULL_WEIGHTS];
        logic signed [WEIGHT_W-1:0] tissue_w [TISSUE_WEIGHTS];
        logic [ACC_W-1:0]           acc;
        int unsigned                coord_count;
        t_coord                     expected_coords[$];
        int                         errors;

        function new();
            foreach (skull_w[n]) skull_w[n] = '0;
            foreach (tissue_w[n]) tissue_w[n] = '0;
            acc         = '0;
            coord_count = 0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_coords.size();
        endfunction

        function void note_beat(t_beat b);
            longint partial;
            longint term;
            longint full;
            t_coord c;
            case (b.operation)
                ttmc_pkg::OP_LOAD_SKULL: begin
                    if (b.skull_index < SKULL_WEIGHTS) skull_w[b.skull_index] = b.weight_value;
                end
                ttmc_pkg::OP_LOAD_TISSUE: begin
                    if (b.tissue_index < TISSUE_WEIGHTS) begin
                        tissue_w[b.tissue_index] = b.weight_value;
                    end
                end
                ttmc_pkg::OP_START: begin
                    // The mean is sign extended into the wide accumulator.
                    acc = ACC_W'(longint'(b.mean_value));
                end
                ttmc_pkg::OP_TERM: begin
                    // Both products are floored back to Q.16 right after each multiply;
                    // an arithmetic shift of a signed value floors toward minus infinity.
                    term = 0;
                    if (b.skull_index < SKULL_WEIGHTS && b.tissue_index < TISSUE_WEIGHTS) begin
                        partial = (longint'(b.tensor_value) *
                                   longint'(skull_w[b.skull_index])) >>> FRAC_SHIFT;
                        term    = (partial * longint'(tissue_w[b.tissue_index])) >>> FRAC_SHIFT;
                    end
                    acc = acc + term[ACC_W-1:0];
                    if (b.final_term) begin
                        full = longint'($signed(acc));
                        c.saturated = 1'b1;
                        if (full > 64'sd2147483647) begin
                            c.coordinate_value = 32'sh7FFFFFFF;
                        end else if (full < -64'sd2147483648) begin
                            c.coordinate_value = 32'sh80000000;
                        end else begin
                            c.coordinate_value = full[COORD_W-1:0];
                            c.saturated        = 1'b0;
                        end
                        c.coordinate_index = coord_count[CINDEX_W-1:0];
                        expected_coords.push_back(c);
                        coord_count = coord_count + 1;
                        if (coord_count >= COORDINATES || coord_count > 32'hFFFF) coord_count = 0;
                        acc = '0;
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(t_coord got);
            t_coord want;
            if (expected_coords.size() == 0) begin
                if (errors < REPORT_LIMIT) begin
                    $display("ERROR: unexpected coordinate value %0d index %0d sat %0b",
                             got.coordinate_value, got.coordinate_index, got.saturated);
                end
                errors++;
                return;
            end
            want = expected_coords.pop_front();
            if (got.coordinate_value !== want.coordinate_value ||
                got.coordinate_index !== want.coordinate_index ||
                got.saturated !== want.saturated) begin
                if (errors < REPORT_LIMIT) begin
                    $display({"ERROR: coordinate expected value %0d index %0d sat %0b,",
                              " got %0d %0d %0b"},
                             want.coordinate_value, want.coordinate_index, want.saturated,
                             got.coordinate_value, got.coordinate_index, got.saturated);
                end
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ttmc_in_if  in_if();
    ttmc_out_if out_if();

    tensor_two_mode_contraction #(
        .SKULL_WEIGHTS (SKULL_WEIGHTS),
        .TISSUE_WEIGHTS(TISSUE_WEIGHTS),
        .COORDINATES   (COORDINATES)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    coordinate_scoreboard sb;

    // Percentages of cycles in which the sender holds back a beat and the receiver
    // refuses one. The main sequence changes them from phase to phase.
    int src_idle_pct;
    int snk_idle_pct;
    int issued;

    // Weight entries are undefined until loaded, so tensor terms only ever pick
    // indices that have already been loaded at least once.
    bit skull_loaded  [SKULL_WEIGHTS];
    bit tissue_loaded [TISSUE_WEIGHTS];
    int skull_ready_q[$];
    int tissue_ready_q[$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a correct run finishes far earlier than this.
    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    // The receiver stalls at random; a fresh decision is made at every edge.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Both channels are sampled at the rising edge, before any of this edge's
    // nonblocking updates land, so every beat is seen with the values it was taken with.
    always @(posedge i_clk) begin
        t_beat  b;
        t_coord c;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                b.operation    = in_if.operation;
                b.skull_index  = in_if.skull_index;
                b.tissue_index = in_if.tissue_index;
                b.weight_value = in_if.weight_value;
                b.mean_value   = in_if.mean_value;
                b.tensor_value = in_if.tensor_value;
                b.final_term   = in_if.final_term;
                sb.note_beat(b);
            end
            if (out_if.valid && out_if.ready) begin
                c.coordinate_value = out_if.coordinate_value;
                c.coordinate_index = out_if.coordinate_index;
                c.saturated        = out_if.saturated;
                sb.check_result(c);
            end
        end
    end

    // A beat with every field random; the builders below then set the fields that the
    // operation actually uses, so the unused ones keep toggling.
    function automatic t_beat random_beat();
        t_beat b;
        b.operation    = ttmc_pkg::t_op'($urandom_range(3));
        b.skull_index  = IDX_W'($urandom_range(63));
        b.tissue_index = IDX_W'($urandom_range(63));
        b.weight_value = WEIGHT_W'($urandom);
        b.mean_value   = MEAN_W'($urandom);
        b.tensor_value = TENSOR_W'($urandom);
        b.final_term   = 1'($urandom_range(1));
        return b;
    endfunction

    function automatic t_beat make_load(ttmc_pkg::t_op op, logic [IDX_W-1:0] idx,
                                        logic signed [WEIGHT_W-1:0] w, logic fin);
        t_beat b;
        b = random_beat();
        b.operation = op;
        if (op == ttmc_pkg::OP_LOAD_SKULL) b.skull_index = idx;
        else b.tissue_index = idx;
        b.weight_value = w;
        b.final_term   = fin;
        return b;
    endfunction

    function automatic t_beat make_start(logic signed [MEAN_W-1:0] mean, logic fin);
        t_beat b;
        b = random_beat();
        b.operation  = ttmc_pkg::OP_START;
        b.mean_value = mean;
        b.final_term = fin;
        return b;
    endfunction

    function automatic t_beat make_term(logic [IDX_W-1:0] j, logic [IDX_W-1:0] k,
                                        logic signed [TENSOR_W-1:0] t, logic fin);
        t_beat b;
        b = random_beat();
        b.operation    = ttmc_pkg::OP_TERM;
        b.skull_index  = j;
        b.tissue_index = k;
        b.tensor_value = t;
        b.final_term   = fin;
        return b;
    endfunction

    // Value generators lean on the extremes, since those drive saturation.
    function automatic logic signed [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sd4096;
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [MEAN_W-1:0] rand_mean();
        case ($urandom_range(9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return 32'sh7FF00000 + MEAN_W'($urandom_range(20'hFFFFF));
            3: return 32'sh80000000 + MEAN_W'($urandom_range(20'hFFFFF));
            default: return MEAN_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [TENSOR_W-1:0] rand_tensor();
        case ($urandom_range(9))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            default: return TENSOR_W'($urandom);
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_skull();
        return IDX_W'(skull_ready_q[$urandom_range(skull_ready_q.size() - 1)]);
    endfunction

    function automatic logic [IDX_W-1:0] pick_tissue();
        return IDX_W'(tissue_ready_q[$urandom_range(tissue_ready_q.size() - 1)]);
    endfunction

    // Presents one beat and returns at the edge that takes it. Valid is left high, so
    // the next call can follow back to back without dropping it in between.
    task automatic issue(t_beat b);
        if (b.operation == ttmc_pkg::OP_LOAD_SKULL && !skull_loaded[b.skull_index]) begin
            skull_loaded[b.skull_index] = 1'b1;
            skull_ready_q.push_back(int'(b.skull_index));
        end
        if (b.operation == ttmc_pkg::OP_LOAD_TISSUE && !tissue_loaded[b.tissue_index]) begin
            tissue_loaded[b.tissue_index] = 1'b1;
            tissue_ready_q.push_back(int'(b.tissue_index));
        end
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.operation    <= b.operation;
        in_if.skull_index  <= b.skull_index;
        in_if.tissue_index <= b.tissue_index;
        in_if.weight_value <= b.weight_value;
        in_if.mean_value   <= b.mean_value;
        in_if.tensor_value <= b.tensor_value;
        in_if.final_term   <= b.final_term;
        do @(posedge i_clk); while (!in_if.ready);
        issued++;
    endtask

    // Holds the sender off until every expected coordinate has come out. The extra edge
    // lets the monitor record the last accepted beat before the queue is looked at.
    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Random traffic is mostly well formed coordinates: a start with its mean and a few
    // terms, the last one final. Weight reloads, orphan terms, lone starts and full
    // drains are mixed in.
    task automatic run_random(input int count);
        int stop_at;
        int pick;
        int n;
        stop_at = issued + count;
        while (issued < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                repeat ($urandom_range(1, 4)) begin
                    issue(make_load(ttmc_pkg::t_op'($urandom_range(1)),
                                    IDX_W'($urandom_range(63)),
                                    rand_weight(), 1'($urandom_range(1))));
                end
            end else if (pick < 82) begin
                issue(make_start(rand_mean(), ($urandom_range(9) == 0)));
                n = $urandom_range(1, 6);
                for (int t = 1; t <= n; t++) begin
                    issue(make_term(pick_skull(), pick_tissue(), rand_tensor(), t == n));
                end
            end else if (pick < 92) begin
                // Terms with no start add onto whatever the accumulator holds.
                n = $urandom_range(1, 3);
                for (int t = 0; t < n; t++) begin
                    issue(make_term(pick_skull(), pick_tissue(), rand_tensor(),
                                    1'($urandom_range(1))));
                end
            end else if (pick < 97) begin
                issue(make_start(rand_mean(), 1'($urandom_range(1))));
            end else begin
                wait_for_results();
            end
        end
    endtask

    initial begin
        sb           = new();
        issued       = 0;
        src_idle_pct = 9;
        snk_idle_pct = 61;
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.operation    <= ttmc_pkg::OP_LOAD_SKULL;
        in_if.skull_index  <= '0;
        in_if.tissue_index <= '0;
        in_if.weight_value <= '0;
        in_if.mean_value   <= '0;
        in_if.tensor_value <= '0;
        in_if.final_term   <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Weight extremes and unity go in first; a final flag on a load
        // must not emit anything.
        issue(make_load(ttmc_pkg::OP_LOAD_SKULL, 6'd0, 16'sh7FFF, 1'b0));
        issue(make_load(ttmc_pkg::OP_LOAD_SKULL, 6'd63, 16'sh8000, 1'b0));
        issue(make_load(ttmc_pkg::OP_LOAD_SKULL, 6'd1, 16'sd4096, 1'b0));
        issue(make_load(ttmc_pkg::OP_LOAD_SKULL, 6'd2, 16'sd0, 1'b1));
        issue(make_load(ttmc_pkg::OP_LOAD_TISSUE, 6'd0, 16'sh8000, 1'b0));
        issue(make_load(ttmc_pkg::OP_LOAD_TISSUE, 6'd63, 16'sh7FFF, 1'b1));
        issue(make_load(ttmc_pkg::OP_LOAD_TISSUE, 6'd1, 16'sd4096, 1'b0));
        issue(make_load(ttmc_pkg::OP_LOAD_TISSUE, 6'd5, -16'sd1, 1'b0));
        // One times one times one gives exactly 1.0 in Q16.16.
        issue(make_start(32'sd0, 1'b0));
        issue(make_term(6'd1, 6'd1, 24'sd65536, 1'b1));
        // Largest mean plus a positive term clips high; the final flag on the start is
        // ignored.
        issue(make_start(32'sh7FFFFFFF, 1'b1));
        issue(make_term(6'd0, 6'd63, 24'sh7FFFFF, 1'b1));
        // Smallest mean plus negative terms clips low.
        issue(make_start(32'sh80000000, 1'b0));
        issue(make_term(6'd0, 6'd0, 24'sh7FFFFF, 1'b0));
        issue(make_term(6'd63, 6'd63, 24'sh7FFFFF, 1'b1));
        // A term with no start, from a cleared accumulator: flooring keeps -1 at -1.
        issue(make_term(6'd1, 6'd1, -24'sd1, 1'b1));
        // More orphan terms, including a zero weight and the most negative tensor entry.
        issue(make_term(6'd2, 6'd5, 24'sd12345, 1'b0));
        issue(make_term(6'd1, 6'd5, 24'sh800000, 1'b0));
        issue(make_term(6'd63, 6'd0, 24'sh800000, 1'b1));
        // A weight reloaded in the middle of a coordinate applies to the later term only.
        issue(make_start(32'sd65536, 1'b0));
        issue(make_term(6'd1, 6'd1, 24'sd65536, 1'b0));
        issue(make_load(ttmc_pkg::OP_LOAD_SKULL, 6'd1, -16'sd4096, 1'b0));
        issue(make_term(6'd1, 6'd1, 24'sd65536, 1'b1));
        // A zero weight leaves the mean alone.
        issue(make_start(-32'sd1, 1'b1));
        issue(make_term(6'd2, 6'd0, 24'sh7FFFFF, 1'b1));

        run_random(300);
        wait_for_results();

        src_idle_pct = 61;
        snk_idle_pct = 9;
        run_random(300);
        wait_for_results();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(300);
        wait_for_results();

        // Let any term still in the pipeline settle before judging.
        repeat (20) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
